/* rtl/core/pcrc_pkg.sv */
// Shared types, constants and CRC helpers for the PNG chunk CRC repair unit.
package pcrc_pkg;

  localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

  typedef enum logic [5:0] {
    ST_SIG  = 6'b000001,
    ST_LEN  = 6'b000010,
    ST_TYPE = 6'b000100,
    ST_DATA = 6'b001000,
    ST_CRC  = 6'b010000,
    ST_PASS = 6'b100000
  } stage_t;

  typedef enum logic [1:0] {
    STATUS_INTACT    = 2'd0,
    STATUS_REPAIRED  = 2'd1,
    STATUS_NOT_PNG   = 2'd2,
    STATUS_TRUNCATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_bad;
    logic       file_end;
    status_t    status;
  } result_t;

  // One byte of the reflected CRC-32 update, unrolled over its eight bits.
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] signature_byte(input logic [2:0] pos);
    return PNG_SIGNATURE[6'd63 - {pos, 3'd0} -: 8];
  endfunction

endpackage

/* rtl/core/pcrc_parser.sv */
// Chunk parser state and per-byte result logic for the PNG chunk CRC repair unit.
module pcrc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output pcrc_pkg::result_t result
);
  import pcrc_pkg::*;

  stage_t      stage, stage_next;
  logic [2:0]  field_pos, field_pos_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] finished_crc, finished_crc_next;
  logic        chunk_mismatch, chunk_mismatch_next;
  logic        any_repaired, any_repaired_next;

  logic [31:0] crc_step;
  logic [31:0] remaining_dec;
  logic [7:0]  crc_byte;
  logic [7:0]  sig_byte;

  assign crc_step      = crc_update(running_crc, data_byte);
  assign remaining_dec = data_remaining - {31'd0, (data_remaining != 32'd0)};
  assign crc_byte      = finished_crc[5'd31 - {field_pos[1:0], 3'd0} -: 8];
  assign sig_byte      = signature_byte(field_pos);

  always_comb begin
    stage_next          = stage;
    field_pos_next      = field_pos;
    data_remaining_next = data_remaining;
    running_crc_next    = running_crc;
    finished_crc_next   = finished_crc;
    chunk_mismatch_next = chunk_mismatch;
    any_repaired_next   = any_repaired;
    result.out_byte     = data_byte;
    result.chunk_bad    = 1'b0;
    result.file_end     = last_byte;
    result.status       = STATUS_INTACT;

    unique case (stage)
      ST_SIG: begin
        if (data_byte != sig_byte) begin
          stage_next     = ST_PASS;
          field_pos_next = 3'd0;
        end else if (field_pos == 3'd7) begin
          stage_next          = ST_LEN;
          field_pos_next      = 3'd0;
          data_remaining_next = 32'd0;
        end else begin
          field_pos_next = field_pos + 3'd1;
        end
      end
      ST_LEN: begin
        data_remaining_next = {data_remaining[23:0], data_byte};
        if (field_pos >= 3'd3) begin
          stage_next     = ST_TYPE;
          field_pos_next = 3'd0;
        end else begin
          field_pos_next = field_pos + 3'd1;
        end
      end
      ST_TYPE: begin
        running_crc_next = crc_step;
        if (field_pos >= 3'd3) begin
          field_pos_next = 3'd0;
          if (data_remaining == 32'd0) begin
            finished_crc_next = ~crc_step;
            stage_next        = ST_CRC;
          end else begin
            stage_next = ST_DATA;
          end
        end else begin
          field_pos_next = field_pos + 3'd1;
        end
      end
      ST_DATA: begin
        running_crc_next    = crc_step;
        data_remaining_next = remaining_dec;
        if (remaining_dec == 32'd0) begin
          finished_crc_next = ~crc_step;
          stage_next        = ST_CRC;
          field_pos_next    = 3'd0;
        end
      end
      ST_CRC: begin
        result.out_byte = crc_byte;
        if (field_pos[1:0] == 2'd3) begin
          result.chunk_bad    = chunk_mismatch || (crc_byte != data_byte);
          any_repaired_next   = any_repaired || result.chunk_bad;
          chunk_mismatch_next = 1'b0;
          running_crc_next    = CRC_INIT;
          data_remaining_next = 32'd0;
          field_pos_next      = 3'd0;
          stage_next          = ST_LEN;
        end else begin
          chunk_mismatch_next = chunk_mismatch || (crc_byte != data_byte);
          field_pos_next      = {1'b0, field_pos[1:0] + 2'd1};
        end
      end
      default: begin
      end
    endcase

    if (last_byte) begin
      if (stage_next == ST_SIG || stage_next == ST_PASS) begin
        result.status = STATUS_NOT_PNG;
      end else if (stage_next == ST_LEN && field_pos_next == 3'd0) begin
        result.status = any_repaired_next ? STATUS_REPAIRED : STATUS_INTACT;
      end else begin
        result.status = STATUS_TRUNCATED;
      end
      stage_next          = ST_SIG;
      field_pos_next      = 3'd0;
      data_remaining_next = 32'd0;
      running_crc_next    = CRC_INIT;
      finished_crc_next   = 32'd0;
      chunk_mismatch_next = 1'b0;
      any_repaired_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= ST_SIG;
      field_pos      <= 3'd0;
      data_remaining <= 32'd0;
      running_crc    <= CRC_INIT;
      finished_crc   <= 32'd0;
      chunk_mismatch <= 1'b0;
      any_repaired   <= 1'b0;
    end else if (step) begin
      stage          <= stage_next;
      field_pos      <= field_pos_next;
      data_remaining <= data_remaining_next;
      running_crc    <= running_crc_next;
      finished_crc   <= finished_crc_next;
      chunk_mismatch <= chunk_mismatch_next;
      any_repaired   <= any_repaired_next;
    end
  end

endmodule

/* rtl/core/png_chunk_crc_repair_unit.sv */
// Top level of the PNG chunk CRC repair unit: handshakes and result register.
//
// The unit takes a PNG file one byte per request on the input channel
// (in_valid, in_ready, data_byte, last_byte) and returns exactly one result
// per byte on the output channel (out_valid, out_ready, out_byte, chunk_bad,
// file_end, status). Bytes inside a stored CRC field are replaced by the
// computed CRC-32 byte; all other bytes pass through unchanged.
// The result of an accepted request is registered and shown by the result
// register from the next cycle on.
// Throughput is one byte per cycle while results are taken, set by the
// byte-wide CRC update and parse logic in front of the result register.
// in_ready is high whenever the result register is empty or being taken, so
// a stalled receiver holds its result and blocks new requests only while
// that result waits.
// Reset empties the result register and puts the parser at the signature.
// After the request that carries last_byte, the parser starts a new file.
module png_chunk_crc_repair_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              chunk_bad,
  output logic              file_end,
  output pcrc_pkg::status_t status
);
  import pcrc_pkg::*;

  logic    accept;
  result_t result;
  result_t result_reg;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  pcrc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_reg <= result;
    end
  end

  assign out_byte  = result_reg.out_byte;
  assign chunk_bad = result_reg.chunk_bad;
  assign file_end  = result_reg.file_end;
  assign status    = result_reg.status;

endmodule

/* rtl/core/pcrc_checker.sv */
// Port-level assertions for the PNG chunk CRC repair unit, with their bind.
module pcrc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              last_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_byte,
  input logic              chunk_bad,
  input logic              file_end,
  input pcrc_pkg::status_t status
);
  import pcrc_pkg::*;

  // The result register leaves reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input is taken whenever the result register is free.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result register is free");

  // Each accepted request shows its result next cycle with its end mark.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (out_valid && file_end == $past(last_byte)))
    else $error("result missing or end mark wrong");

  // Status is meaningful only at file end and is zero elsewhere.
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !file_end) |-> (status == STATUS_INTACT))
    else $error("status nonzero away from file end");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(chunk_bad) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind png_chunk_crc_repair_unit pcrc_checker u_pcrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .chunk_bad (chunk_bad),
  .file_end  (file_end),
  .status    (status)
);

/* dv/tb_top.sv */
// Testbench for the PNG chunk CRC repair unit: random PNG files checked byte by byte.
module tb_top;
  import pcrc_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       last;
    bit         drain;
  } byte_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       chunk_bad;
  logic       file_end;
  status_t    status;

  byte_req_t  file_bytes[$];
  logic [7:0] file_build[$];
  result_t    repaired_bytes_due[$];

  stage_t      png_stage;
  logic [2:0]  field_pos;
  logic [31:0] bytes_left;
  logic [31:0] run_crc;
  logic [31:0] done_crc;
  logic        crc_mismatch;
  logic        any_fixed;
  logic        sig_failed;

  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int send_gap = 0;
  int take_wait = 0;

  png_chunk_crc_repair_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .chunk_bad (chunk_bad),
    .file_end  (file_end),
    .status    (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void clear_parser();
    png_stage    = ST_SIG;
    field_pos    = 3'd0;
    bytes_left   = 32'd0;
    run_crc      = CRC_INIT;
    done_crc     = 32'd0;
    crc_mismatch = 1'b0;
    any_fixed    = 1'b0;
    sig_failed   = 1'b0;
  endfunction

  function automatic result_t predict_repair(input logic [7:0] b, input logic last);
    result_t    r;
    logic [1:0] pos;
    r.out_byte  = b;
    r.chunk_bad = 1'b0;
    r.file_end  = last;
    r.status    = STATUS_INTACT;
    case (png_stage)
      ST_SIG: begin
        if (b != PNG_SIGNATURE[8 * (7 - field_pos) +: 8]) begin
          sig_failed = 1'b1;
          png_stage  = ST_PASS;
          field_pos  = 3'd0;
        end else if (field_pos == 3'd7) begin
          png_stage  = ST_LEN;
          field_pos  = 3'd0;
          bytes_left = 32'd0;
        end else begin
          field_pos = field_pos + 3'd1;
        end
      end
      ST_LEN: begin
        bytes_left = {bytes_left[23:0], b};
        if (field_pos >= 3'd3) begin
          png_stage = ST_TYPE;
          field_pos = 3'd0;
        end else begin
          field_pos = field_pos + 3'd1;
        end
      end
      ST_TYPE: begin
        run_crc = crc32_byte(run_crc, b);
        if (field_pos >= 3'd3) begin
          field_pos = 3'd0;
          if (bytes_left == 32'd0) begin
            done_crc  = ~run_crc;
            png_stage = ST_CRC;
          end else begin
            png_stage = ST_DATA;
          end
        end else begin
          field_pos = field_pos + 3'd1;
        end
      end
      ST_DATA: begin
        run_crc = crc32_byte(run_crc, b);
        if (bytes_left != 32'd0) begin
          bytes_left = bytes_left - 32'd1;
        end
        if (bytes_left == 32'd0) begin
          done_crc  = ~run_crc;
          png_stage = ST_CRC;
          field_pos = 3'd0;
        end
      end
      ST_CRC: begin
        pos = field_pos[1:0];
        r.out_byte = done_crc[8 * (3 - pos) +: 8];
        if (r.out_byte != b) begin
          crc_mismatch = 1'b1;
        end
        if (pos == 2'd3) begin
          r.chunk_bad  = crc_mismatch;
          any_fixed    = any_fixed | crc_mismatch;
          crc_mismatch = 1'b0;
          run_crc      = CRC_INIT;
          bytes_left   = 32'd0;
          field_pos    = 3'd0;
          png_stage    = ST_LEN;
        end else begin
          field_pos = field_pos + 3'd1;
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      if (sig_failed || png_stage == ST_SIG || png_stage == ST_PASS) begin
        r.status = STATUS_NOT_PNG;
      end else if (png_stage == ST_LEN && field_pos == 3'd0) begin
        r.status = any_fixed ? STATUS_REPAIRED : STATUS_INTACT;
      end else begin
        r.status = STATUS_TRUNCATED;
      end
      clear_parser();
    end
    return r;
  endfunction

  task automatic put_signature();
    for (int i = 0; i < 8; i++) begin
      file_build.push_back(PNG_SIGNATURE[8 * (7 - i) +: 8]);
    end
  endtask

  task automatic put_length(input logic [31:0] len);
    for (int i = 0; i < 4; i++) begin
      file_build.push_back(len[8 * (3 - i) +: 8]);
    end
  endtask

  task automatic put_chunk(input logic [31:0] len, input bit spoil);
    logic [31:0] c;
    logic [7:0]  v;
    put_length(len);
    c = CRC_INIT;
    for (int i = 0; i < 4 + len; i++) begin
      v = 8'($urandom);
      file_build.push_back(v);
      c = crc32_byte(c, v);
    end
    c = ~c;
    if (spoil) begin
      if ($urandom_range(0, 3) == 0) begin
        c = c ^ $urandom;
      end else begin
        c = c ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
      end
    end
    put_length(c);
  endtask

  task automatic cut_file(input int keep);
    while (file_build.size() > keep) begin
      void'(file_build.pop_back());
    end
  endtask

  task automatic commit_file(input bit drain);
    byte_req_t req;
    for (int i = 0; i < file_build.size(); i++) begin
      req.value = file_build[i];
      req.last  = (i == file_build.size() - 1);
      req.drain = drain && (i == 0);
      file_bytes.push_back(req);
    end
    file_build.delete();
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got,
               want);
    end
  endtask

  task automatic build_files();
    int   pick;
    int   idx;
    int   nchunks;
    logic [31:0] len;
    bit   first;
    // A file cut inside the signature, one that fails it early, and a bare signature.
    file_build = '{8'h89, 8'h50};
    commit_file(1'b0);
    file_build = '{8'h89, 8'hFF, 8'h00};
    commit_file(1'b0);
    put_signature();
    commit_file(1'b0);
    // The largest length, with the file ending inside the type field.
    put_signature();
    put_length(32'hFFFF_FFFF);
    file_build.push_back(8'h00);
    file_build.push_back(8'hFF);
    commit_file(1'b0);
    first = 1'b1;
    while (file_bytes.size() < 1980) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        put_signature();
        nchunks = $urandom_range(1, 3);
        for (int k = 0; k < nchunks; k++) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          put_chunk(len, $urandom_range(0, 2) == 0);
        end
        if (pick >= 60) begin
          cut_file($urandom_range(1, file_build.size() - 1));
        end
      end else if (pick < 85) begin
        put_signature();
        idx = $urandom_range(0, 7);
        file_build[idx] = file_build[idx] ^ 8'($urandom_range(1, 255));
        cut_file(idx + 1);
        repeat ($urandom_range(0, 10)) file_build.push_back(8'($urandom));
      end else if (pick < 90) begin
        put_signature();
        cut_file($urandom_range(1, 7));
      end else if (pick < 95) begin
        put_signature();
        put_length(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h0100_0000));
        repeat ($urandom_range(0, 12)) file_build.push_back(8'($urandom));
      end else begin
        put_signature();
      end
      commit_file(first || ($urandom_range(0, 7) == 0));
      first = 1'b0;
    end
  endtask

  always @(posedge clk) begin : drive_requests
    byte_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        repaired_bytes_due.push_back(predict_repair(data_byte, last_byte));
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (file_bytes.size() > 0 &&
                     !(file_bytes[0].drain && repaired_bytes_due.size() > 0)) begin
          req = file_bytes.pop_front();
          data_byte <= req.value;
          last_byte <= req.last;
          in_valid  <= 1'b1;
          send_gap = (((bytes_sent / 200) % 3) == 2) ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (repaired_bytes_due.size() == 0) begin
          report_mismatch("result with no request outstanding, out_byte", out_byte, 0);
        end else begin
          want = repaired_bytes_due.pop_front();
          if (out_byte !== want.out_byte) begin
            report_mismatch("out_byte", out_byte, want.out_byte);
          end
          if (chunk_bad !== want.chunk_bad) begin
            report_mismatch("chunk_bad", chunk_bad, want.chunk_bad);
          end
          if (file_end !== want.file_end) begin
            report_mismatch("file_end", file_end, want.file_end);
          end
          if (status !== want.status) begin
            report_mismatch("status", int'(status), int'(want.status));
          end
        end
        results_seen++;
        if (results_seen == 500 || results_seen == 1400) begin
          take_wait = 400;
        end else begin
          take_wait = (((results_seen / 170) % 4) == 1) ? 0 : $urandom_range(0, 14);
        end
      end
      if (take_wait > 0) begin
        take_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    clear_parser();
    build_files();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do begin
      @(negedge clk);
    end while (file_bytes.size() > 0 || in_valid || repaired_bytes_due.size() > 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && repaired_bytes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(8 * 600000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
